// ===== src/isrd_pkg.sv =====
package isrd_pkg;

  localparam int ADDR_W     = 20;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    MODE_RAW         = 3'd0,
    MODE_MONO        = 3'd1,
    MODE_MONO_RLE    = 3'd2,
    MODE_RLE         = 3'd3,
    MODE_LOSSY       = 3'd4,
    MODE_REDUCED     = 3'd5,
    MODE_REDUCED_RLE = 3'd6
  } mode_t;

  localparam logic [15:0] PIX_WHITE = 16'hFFFF;
  localparam logic [15:0] PIX_BLACK = 16'h0000;

  // One queued run. For a mono entry, value[7:0] holds the bitmap byte
  // and the back end splits it into eight single-pixel runs.
  typedef struct packed {
    logic              mono;
    logic [15:0]       value;
    logic [8:0]        length;
    logic [ADDR_W-1:0] addr;
  } run_entry_t;

  function automatic logic [15:0] expand332(input logic [7:0] p);
    logic [2:0] r;
    logic [2:0] g;
    logic [1:0] b;
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r  = p[7:5];
    g  = p[4:2];
    b  = p[1:0];
    r5 = {r, 2'b00} | {3'b000, r[2:1]};
    g6 = {g, 3'b000} | {2'b00, g, 1'b0} | {5'b00000, g[2]};
    b5 = {b, 3'b000} | {2'b00, b, 1'b0} | {4'b0000, b[1]};
    return {r5, g6, b5};
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    if (v < 12'sd0) begin
      return 8'd0;
    end else if (v > 12'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

  // Fixed-point YCbCr to RGB565, coefficients scaled by 1024, floor shifts.
  function automatic logic [15:0] ycc_to_565(input logic [7:0] yb,
                                             input logic [7:0] cbb,
                                             input logic [7:0] crb);
    logic signed [8:0]  cb;
    logic signed [8:0]  cr;
    logic signed [20:0] p_r;
    logic signed [20:0] p_gb;
    logic signed [20:0] p_gr;
    logic signed [20:0] p_b;
    logic signed [10:0] d_r;
    logic signed [10:0] d_gb;
    logic signed [10:0] d_gr;
    logic signed [10:0] d_b;
    logic signed [11:0] ys;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    cb   = $signed({1'b0, cbb}) - 9'sd128;
    cr   = $signed({1'b0, crb}) - 9'sd128;
    p_r  = cr * 21'sd1436;
    p_gb = cb * 21'sd352;
    p_gr = cr * 21'sd731;
    p_b  = cb * 21'sd1815;
    d_r  = p_r[20:10];
    d_gb = p_gb[20:10];
    d_gr = p_gr[20:10];
    d_b  = p_b[20:10];
    ys   = $signed({4'b0000, yb});
    r = clamp8(ys + {d_r[10], d_r});
    g = clamp8(ys - {d_gb[10], d_gb} - {d_gr[10], d_gr});
    b = clamp8(ys + {d_b[10], d_b});
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== src/isrd_front.sv =====
module isrd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   decode_mode_wr_en,
  input  logic [2:0]             decode_mode,
  input  logic                   accept,
  input  logic [7:0]             stream_byte,
  input  logic                   last_byte,
  output logic                   push,
  output isrd_pkg::run_entry_t   push_entry
);

  logic [2:0]                  mode;
  logic [1:0]                  phase;
  logic [1:0]                  phase_next;
  logic [7:0]                  held_count;
  logic [7:0]                  held_count_next;
  logic [15:0]                 held_bytes;
  logic [15:0]                 held_bytes_next;
  logic [isrd_pkg::ADDR_W-1:0] position;
  logic [isrd_pkg::ADDR_W-1:0] position_next;
  logic                        emit;
  logic                        is_mono;
  logic [15:0]                 value;
  logic [8:0]                  length;

  always_comb begin
    phase_next      = 2'd0;
    held_count_next = held_count;
    held_bytes_next = held_bytes;
    emit            = 1'b0;
    is_mono         = 1'b0;
    value           = {held_bytes[7:0], stream_byte};
    length          = 9'd1;
    unique case (mode)
      isrd_pkg::MODE_MONO: begin
        emit    = 1'b1;
        is_mono = 1'b1;
        value   = {8'h00, stream_byte};
        length  = 9'd8;
      end
      isrd_pkg::MODE_MONO_RLE: begin
        emit   = 1'b1;
        value  = stream_byte[0] ? isrd_pkg::PIX_WHITE : isrd_pkg::PIX_BLACK;
        length = {2'b00, stream_byte[7:1]};
      end
      isrd_pkg::MODE_RLE: begin
        if (phase == 2'd0) begin
          held_count_next = stream_byte;
          phase_next      = 2'd1;
        end else if (phase == 2'd1) begin
          held_bytes_next = {8'h00, stream_byte};
          phase_next      = 2'd2;
        end else begin
          emit   = 1'b1;
          length = {1'b0, held_count};
        end
      end
      isrd_pkg::MODE_LOSSY: begin
        if (phase == 2'd0) begin
          held_count_next = stream_byte;
          phase_next      = 2'd1;
        end else if (phase != 2'd3) begin
          held_bytes_next = {held_bytes[7:0], stream_byte};
          phase_next      = phase + 2'd1;
        end else begin
          emit   = 1'b1;
          value  = isrd_pkg::ycc_to_565(held_bytes[15:8], held_bytes[7:0], stream_byte);
          length = {held_count, 1'b0};
        end
      end
      isrd_pkg::MODE_REDUCED: begin
        emit  = 1'b1;
        value = isrd_pkg::expand332(stream_byte);
      end
      isrd_pkg::MODE_REDUCED_RLE: begin
        if (phase == 2'd0) begin
          held_count_next = stream_byte;
          phase_next      = 2'd1;
        end else begin
          emit   = 1'b1;
          value  = isrd_pkg::expand332(stream_byte);
          length = {1'b0, held_count};
        end
      end
      default: begin
        // raw, and the unused code decodes as raw
        if (phase == 2'd0) begin
          held_bytes_next = {8'h00, stream_byte};
          phase_next      = 2'd1;
        end else begin
          emit = 1'b1;
        end
      end
    endcase

    // zero-count records give no run
    if (length == 9'd0) begin
      emit = 1'b0;
    end

    position_next = emit ? position + isrd_pkg::ADDR_W'(length) : position;
    if (last_byte) begin
      phase_next    = 2'd0;
      position_next = '0;
    end
  end

  assign push             = accept && emit;
  assign push_entry.mono  = is_mono;
  assign push_entry.value = value;
  assign push_entry.length = length;
  assign push_entry.addr  = position;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= isrd_pkg::MODE_RAW;
      phase      <= 2'd0;
      held_count <= 8'd0;
      held_bytes <= 16'd0;
      position   <= '0;
    end else if (decode_mode_wr_en) begin
      mode       <= decode_mode;
      phase      <= 2'd0;
      held_count <= 8'd0;
      held_bytes <= 16'd0;
      position   <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      held_count <= held_count_next;
      held_bytes <= held_bytes_next;
      position   <= position_next;
    end
  end

endmodule

// ===== src/isrd_fifo.sv =====
module isrd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  isrd_pkg::run_entry_t push_entry,
  input  logic                 pop,
  output isrd_pkg::run_entry_t head,
  output logic                 empty,
  output logic                 full
);

  isrd_pkg::run_entry_t               entries [isrd_pkg::FIFO_DEPTH];
  logic [isrd_pkg::FIFO_AW-1:0]       wr_ptr;
  logic [isrd_pkg::FIFO_AW-1:0]       rd_ptr;
  logic [isrd_pkg::FIFO_AW:0]         count;

  assign empty = (count == '0);
  assign full  = (count == (isrd_pkg::FIFO_AW+1)'(isrd_pkg::FIFO_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/isrd_back.sv =====
module isrd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  isrd_pkg::run_entry_t        head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 pixel_value,
  output logic [8:0]                  run_length,
  output logic [19:0]                 start_address,
  output logic                        last_of_item
);

  logic       load;
  logic       take;
  logic [2:0] sub;
  logic [7:0] mono_byte;
  logic       mono_bit;
  logic       mono_done;

  assign load      = !out_valid || !out_stall;
  assign take      = load && !empty;
  assign mono_byte = head.value[7:0];
  assign mono_bit  = mono_byte[~sub];
  assign mono_done = (sub == 3'd7);
  assign pop       = take && (!head.mono || mono_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (take && head.mono) begin
        sub <= sub + 3'd1;
      end
    end
  end

  // start_address is the low 20 bits of the wrapping pixel address
  always_ff @(posedge clk) begin
    if (take) begin
      if (head.mono) begin
        pixel_value   <= mono_bit ? isrd_pkg::PIX_WHITE : isrd_pkg::PIX_BLACK;
        run_length    <= 9'd1;
        start_address <= 20'(head.addr + isrd_pkg::ADDR_W'(sub));
        last_of_item  <= mono_done;
      end else begin
        pixel_value   <= head.value;
        run_length    <= head.length;
        start_address <= 20'(head.addr);
        last_of_item  <= 1'b1;
      end
    end
  end

endmodule

// ===== src/image_stream_rle_decoder.sv =====
// Compressed image stream to RGB565 run decoder. One stream byte is taken per
// cycle on the in channel unless the queue is full; each completed record is
// classified by the front end and queued (four entries) as a run of value,
// length and start address; the back end hands runs out through a registered
// output. While out_stall is low every mode sustains one byte per clock, except
// monochrome: each of its bytes gives eight single-pixel runs, one per cycle
// from the back end, so that mode stalls the input once the queue fills. A
// write of decode_mode clears the record phase and the pixel address; write it
// only while no run is pending. A byte with last_byte set drops any partial
// record and restarts the address at zero.
module image_stream_rle_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        decode_mode_wr_en,
  input  logic [2:0]  decode_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_value,
  output logic [8:0]  run_length,
  output logic [19:0] start_address,
  output logic        last_of_item
);

  isrd_pkg::run_entry_t push_entry;
  isrd_pkg::run_entry_t head;
  logic                 accept;
  logic                 push;
  logic                 pop;
  logic                 empty;
  logic                 full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  isrd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .decode_mode_wr_en (decode_mode_wr_en),
    .decode_mode       (decode_mode),
    .accept            (accept),
    .stream_byte       (stream_byte),
    .last_byte         (last_byte),
    .push              (push),
    .push_entry        (push_entry)
  );

  isrd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  isrd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_value   (pixel_value),
    .run_length    (run_length),
    .start_address (start_address),
    .last_of_item  (last_of_item)
  );

endmodule

// ===== verif/image_stream_rle_decoder_test.sv =====
`timescale 1ns / 1ps

module image_stream_rle_decoder_test;

  localparam logic [2:0] MODE_SPARE = 3'd7;  // unused code, decodes as raw
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_item_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [8:0]  length;
    logic [19:0] addr;
    logic        is_last;
  } run_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        decode_mode_wr_en = 1'b0;
  logic [2:0]  decode_mode = 3'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  stream_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pixel_value;
  logic [8:0]  run_length;
  logic [19:0] start_address;
  logic        last_of_item;

  image_stream_rle_decoder dut (
    .clk               (clk),
    .rst               (rst),
    .decode_mode_wr_en (decode_mode_wr_en),
    .decode_mode       (decode_mode),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .stream_byte       (stream_byte),
    .last_byte         (last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pixel_value       (pixel_value),
    .run_length        (run_length),
    .start_address     (start_address),
    .last_of_item      (last_of_item)
  );

  always #6 clk = ~clk;

  // Decoder shadow state
  logic [2:0]  pred_mode = isrd_pkg::MODE_RAW;
  logic [1:0]  rec_phase = 2'd0;
  logic [7:0]  rec_count = 8'd0;
  logic [23:0] rec_bytes = 24'd0;
  logic [19:0] pix_addr = 20'd0;
  run_t        run_batch [8];
  int          batch_len;

  stream_item_t bytes_to_send [$];
  run_t         expected_runs [$];
  int bytes_outstanding = 0;
  int bytes_accepted = 0;
  int runs_checked = 0;
  int modes_written = 0;
  int fail_count = 0;
  int mismatch_shown = 0;
  int hold_requests = 0;

  function automatic int sat8(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic logic [15:0] rgb332_to_565(input logic [7:0] p);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = {p[7:5], p[7:6]};
    g6 = {p[4:2], 3'b000} | {2'b00, p[4:2], 1'b0} | {5'b00000, p[4]};
    b5 = {p[1:0], 3'b000} | {2'b00, p[1:0], 1'b0} | {4'b0000, p[1]};
    return {r5, g6, b5};
  endfunction

  // >>> on int floors toward minus infinity
  function automatic logic [15:0] ycc_pixel(input logic [7:0] yv, input logic [7:0] cbv,
                                            input logic [7:0] crv);
    int y, cb, cr, r, g, b;
    y  = int'(yv);
    cb = int'(cbv) - 128;
    cr = int'(crv) - 128;
    r  = sat8(y + ((cr * 1436) >>> 10));
    g  = sat8(y - ((cb * 352) >>> 10) - ((cr * 731) >>> 10));
    b  = sat8(y + ((cb * 1815) >>> 10));
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic void add_run(input logic [15:0] v, input logic [8:0] len);
    if (len != 9'd0) begin
      run_batch[batch_len] = '{pixel: v, length: len, addr: pix_addr, is_last: 1'b0};
      batch_len++;
      pix_addr = pix_addr + 20'(len);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic l);
    run_t r;
    batch_len = 0;
    case (pred_mode)
      isrd_pkg::MODE_MONO: begin
        for (int j = 7; j >= 0; j--) begin
          add_run(b[j] ? isrd_pkg::PIX_WHITE : isrd_pkg::PIX_BLACK, 9'd1);
        end
        rec_phase = 2'd0;
      end
      isrd_pkg::MODE_MONO_RLE: begin
        add_run(b[0] ? isrd_pkg::PIX_WHITE : isrd_pkg::PIX_BLACK, {2'b00, b[7:1]});
        rec_phase = 2'd0;
      end
      isrd_pkg::MODE_RLE: begin
        if (rec_phase == 2'd0) begin
          rec_count = b;
          rec_phase = 2'd1;
        end else if (rec_phase == 2'd1) begin
          rec_bytes = {16'd0, b};
          rec_phase = 2'd2;
        end else begin
          add_run({rec_bytes[7:0], b}, {1'b0, rec_count});
          rec_phase = 2'd0;
        end
      end
      isrd_pkg::MODE_LOSSY: begin
        if (rec_phase == 2'd0) begin
          rec_count = b;
          rec_phase = 2'd1;
        end else if (rec_phase != 2'd3) begin
          rec_bytes = {rec_bytes[15:0], b};
          rec_phase = rec_phase + 2'd1;
        end else begin
          add_run(ycc_pixel(rec_bytes[15:8], rec_bytes[7:0], b), {rec_count, 1'b0});
          rec_phase = 2'd0;
        end
      end
      isrd_pkg::MODE_REDUCED: begin
        add_run(rgb332_to_565(b), 9'd1);
        rec_phase = 2'd0;
      end
      isrd_pkg::MODE_REDUCED_RLE: begin
        if (rec_phase == 2'd0) begin
          rec_count = b;
          rec_phase = 2'd1;
        end else begin
          add_run(rgb332_to_565(b), {1'b0, rec_count});
          rec_phase = 2'd0;
        end
      end
      default: begin
        if (rec_phase == 2'd0) begin
          rec_bytes = {16'd0, b};
          rec_phase = 2'd1;
        end else begin
          add_run({rec_bytes[7:0], b}, 9'd1);
          rec_phase = 2'd0;
        end
      end
    endcase
    for (int k = 0; k < batch_len; k++) begin
      r = run_batch[k];
      r.is_last = (k == batch_len - 1);
      expected_runs.push_back(r);
    end
    if (l) begin
      rec_phase = 2'd0;
      pix_addr = 20'd0;
    end
  endfunction

  // Sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    stream_item_t item;
    int pick;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(stream_byte, last_byte);
        bytes_outstanding--;
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          item = bytes_to_send.pop_front();
          stream_byte <= item.data;
          last_byte <= item.last;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 60);
            pick = $urandom_range(0, 9);
            if (pick < 4) gap_left = 0;
            else if (pick < 8) gap_left = $urandom_range(1, 4);
            else if (pick < 9) gap_left = $urandom_range(5, 12);
            else gap_left = $urandom_range(20, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with long holds counted here on request
  stall_style_t stall_style = STALL_NONE;
  int style_left = 0;
  int holds_granted = 0;
  int long_hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_granted != hold_requests) begin
        holds_granted++;
        long_hold_left = LONG_HOLD_CYCLES;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = stall_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(20, 300);
        end else begin
          style_left--;
        end
        case (stall_style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:     out_stall <= ((style_left % 7) < 3);
        endcase
      end
    end
  end

  // Run checker
  always @(posedge clk) begin
    run_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        fail_count++;
        if (mismatch_shown < 10) begin
          mismatch_shown++;
          $display("unexpected run: pixel %h len %0d addr %h last %b",
                   pixel_value, run_length, start_address, last_of_item);
        end
      end else begin
        want = expected_runs.pop_front();
        runs_checked++;
        if (pixel_value !== want.pixel || run_length !== want.length ||
            start_address !== want.addr || last_of_item !== want.is_last) begin
          fail_count++;
          if (mismatch_shown < 10) begin
            mismatch_shown++;
            $display("run mismatch: want pixel %h len %0d addr %h last %b", want.pixel,
                     want.length, want.addr, want.is_last);
            $display("              got  pixel %h len %0d addr %h last %b", pixel_value,
                     run_length, start_address, last_of_item);
          end
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic l);
    bytes_to_send.push_back(stream_item_t'{data: b, last: l});
    bytes_outstanding++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (bytes_outstanding != 0 || expected_runs.size() != 0);
  endtask

  // Mode writes only once the decoder is idle; a write clears record and address
  task automatic set_mode(input logic [2:0] m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    decode_mode_wr_en <= 1'b1;
    decode_mode <= m;
    pred_mode = m;
    rec_phase = 2'd0;
    rec_count = 8'd0;
    rec_bytes = 24'd0;
    pix_addr = 20'd0;
    modes_written++;
    @(posedge clk);
    decode_mode_wr_en <= 1'b0;
  endtask

  function automatic int record_bytes(input logic [2:0] m);
    case (m)
      isrd_pkg::MODE_MONO, isrd_pkg::MODE_MONO_RLE, isrd_pkg::MODE_REDUCED: return 1;
      isrd_pkg::MODE_RLE: return 3;
      isrd_pkg::MODE_LOSSY: return 4;
      default: return 2;
    endcase
  endfunction

  function automatic logic [7:0] pick_count();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    if (pick == 2) return 8'd1;
    if (pick < 6) return 8'($urandom_range(1, 8));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly whole records with random content; some noise and cut-off records
  task automatic push_records(input logic [2:0] m, input int n_bytes);
    int sent, len, cut;
    bit chop;
    bit counted;
    logic [7:0] b;
    sent = 0;
    counted = (m == isrd_pkg::MODE_RLE) || (m == isrd_pkg::MODE_LOSSY) ||
              (m == isrd_pkg::MODE_REDUCED_RLE);
    while (sent < n_bytes) begin
      if ($urandom_range(0, 14) == 0) begin
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = record_bytes(m);
        chop = (len > 1) && ($urandom_range(0, 19) == 0);
        cut = chop ? $urandom_range(0, len - 2) : len - 1;
        for (int k = 0; k <= cut; k++) begin
          b = (k == 0 && counted) ? pick_count() : 8'($urandom_range(0, 255));
          push_byte(b, chop ? (k == cut) : (k == cut && $urandom_range(0, 11) == 0));
        end
        sent += cut + 1;
      end
    end
  endtask

  initial begin
    logic [2:0] tour [8];
    logic [2:0] m;
    tour[0] = isrd_pkg::MODE_REDUCED;
    tour[1] = isrd_pkg::MODE_RLE;
    tour[2] = isrd_pkg::MODE_MONO;
    tour[3] = MODE_SPARE;
    tour[4] = isrd_pkg::MODE_LOSSY;
    tour[5] = isrd_pkg::MODE_MONO_RLE;
    tour[6] = isrd_pkg::MODE_REDUCED_RLE;
    tour[7] = isrd_pkg::MODE_RAW;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Raw at reset: extreme pixels, then a lone byte ending the stream
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b1);

    // Mono under a long output hold so the run queue backs up into the input
    set_mode(isrd_pkg::MODE_MONO);
    hold_requests++;
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_records(isrd_pkg::MODE_MONO, 12);

    // Mono RLE: longest white run, zero counts of both colors
    set_mode(isrd_pkg::MODE_MONO_RLE);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);

    // RLE: zero count, then longest run of white
    set_mode(isrd_pkg::MODE_RLE);
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);

    // Lossy: chroma at both extremes so red clamps at both ends
    set_mode(isrd_pkg::MODE_LOSSY);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);

    for (int i = 0; i < 14; i++) begin
      m = (i < 8) ? tour[i] : 3'($urandom_range(0, 7));
      set_mode(m);
      if (m == isrd_pkg::MODE_MONO || m == isrd_pkg::MODE_RLE) hold_requests++;
      if (i % 3 == 2) begin
        // sender stops mid-stream until every pending run is out
        push_records(m, 14);
        wait_drained();
        push_records(m, 14);
      end else begin
        push_records(m, 28);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (expected_runs.size() != 0) fail_count++;

    $display("covered %0d stream bytes and %0d runs over %0d mode writes,", bytes_accepted,
             runs_checked, modes_written);
    $display("with every mode code, zero counts, cut-off records and long output back-pressure");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("timeout waiting for the decoder");
    $display("status: fail");
    $finish;
  end

endmodule
